/* design/scob_pkg.sv */
package scob_pkg;

    // Largest byte value, used as the full-scale alpha.
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    // Configuration register index width and register map.
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED   = 3'd0,
        CFG_GREEN = 3'd1,
        CFG_BLUE  = 3'd2,
        CFG_ALPHA = 3'd3,
        CFG_MODE  = 3'd4
    } cfg_index_t;

    // Destination pixel formats.
    localparam logic [1:0] MODE_RGB24 = 2'd0;
    localparam logic [1:0] MODE_RGB32 = 2'd1;
    localparam logic [1:0] MODE_ARGB  = 2'd2;

    typedef struct packed {
        logic [7:0] dest_blue;
        logic [7:0] dest_green;
        logic [7:0] dest_red;
        logic [7:0] dest_alpha_in;
    } dest_pixel_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } result_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] mode;
    } fill_cfg_t;

    // How the back end finishes an item.
    typedef enum logic [2:0] {
        CLS_PASS          = 3'd0,  // pixel unchanged
        CLS_FILL_KEEP     = 3'd1,  // fill color, keep fourth byte
        CLS_FILL_OPAQUE   = 3'd2,  // fill color, alpha 255
        CLS_FILL_SRC      = 3'd3,  // fill color, alpha from fill
        CLS_MERGE_KEEP    = 3'd4,  // merged channels, keep fourth byte
        CLS_MERGE_OPAQUE  = 3'd5,  // merged channels, alpha 255
        CLS_BLEND         = 3'd6   // source-over onto an argb pixel
    } blend_class_t;

    typedef struct packed {
        blend_class_t cls;
        dest_pixel_t  pix;
    } work_item_t;

    // Exact x / 255 for x up to 255 * 255, by reciprocal with correction.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            div255 = sum[15:8];
        end
    endfunction

endpackage

/* design/solid_color_over_blend.sv */
// Items pass the queue, product, divider, merge and result registers, at every rate.
// Throughput: one item per cycle; the back end is a fixed pipeline that never stalls.
// The 8-stage alpha-ratio divider sets the latency; the 2-entry queue keeps busy low.
// The receiver cannot stall, so results leave on a fixed schedule.
// Reset (rst_n low, asynchronous) empties the queue and pipeline and loads
// the fill color black, fill alpha 255 and the argb format.
module solid_color_over_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  scob_pkg::dest_pixel_t          dest,
    output logic                           result_valid,
    output scob_pkg::result_pixel_t        result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import scob_pkg::*;

    logic       push;
    work_item_t push_item;
    logic       queue_full;
    logic       pop_valid;
    work_item_t pop_item;
    fill_cfg_t  cfg;

    // Registers are always writable.
    assign cfg_ready = 1'b1;
    assign busy      = queue_full;

    // Front end: configuration and item classification.
    scob_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .queue_full (queue_full),
        .dest       (dest),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_item  (push_item),
        .cfg        (cfg)
    );

    // Queue between the front and back ends.
    scob_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    // Back end: blend arithmetic.
    scob_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pop_valid),
        .in_item      (pop_item),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* design/scob_front.sv */
module scob_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           queue_full,
    input  scob_pkg::dest_pixel_t          dest,
    input  logic                           cfg_valid,
    input  logic [scob_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           push,
    output scob_pkg::work_item_t           push_item,
    output scob_pkg::fill_cfg_t            cfg
);
    import scob_pkg::*;

    fill_cfg_t cfg_reg;

    // Configuration registers; indexes past the map are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red   <= 8'd0;
            cfg_reg.green <= 8'd0;
            cfg_reg.blue  <= 8'd0;
            cfg_reg.alpha <= BYTE_MAX;
            cfg_reg.mode  <= MODE_ARGB;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RED:   cfg_reg.red   <= cfg_data;
                CFG_GREEN: cfg_reg.green <= cfg_data;
                CFG_BLUE:  cfg_reg.blue  <= cfg_data;
                CFG_ALPHA: cfg_reg.alpha <= cfg_data;
                CFG_MODE:  cfg_reg.mode  <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // An item is taken whenever the queue has room.
    assign push = start && !queue_full;

    // Classify the item so that the back end only has to select.
    always_comb
    begin
        push_item.pix = dest;
        if (cfg_reg.alpha == 8'd0 || cfg_reg.mode > MODE_ARGB)
        begin
            push_item.cls = CLS_PASS;
        end
        else if (cfg_reg.alpha == BYTE_MAX)
        begin
            push_item.cls = (cfg_reg.mode == MODE_RGB24) ? CLS_FILL_KEEP : CLS_FILL_OPAQUE;
        end
        else if (cfg_reg.mode == MODE_ARGB)
        begin
            push_item.cls = (dest.dest_alpha_in == 8'd0) ? CLS_FILL_SRC : CLS_BLEND;
        end
        else
        begin
            push_item.cls = (cfg_reg.mode == MODE_RGB32) ? CLS_MERGE_OPAQUE : CLS_MERGE_KEEP;
        end
    end

endmodule

/* design/scob_queue.sv */
module scob_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  scob_pkg::work_item_t push_item,
    output logic                 full,
    output logic                 pop_valid,
    output scob_pkg::work_item_t pop_item
);
    import scob_pkg::*;

    work_item_t  entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;

    // The back end never stalls, so every waiting item leaves at once.
    assign pop       = (count_reg != 2'd0);
    assign pop_valid = pop;
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* design/scob_back.sv */
module scob_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  scob_pkg::work_item_t    in_item,
    input  scob_pkg::fill_cfg_t     cfg,
    output logic                    result_valid,
    output scob_pkg::result_pixel_t result
);
    import scob_pkg::*;

    localparam int unsigned DIV_STEPS = 8;

    typedef struct packed {
        blend_class_t cls;
        dest_pixel_t  pix;
        logic [7:0]   ra;
        logic [7:0]   divisor;
        logic [15:0]  rem;
        logic [7:0]   quot;
    } div_stage_t;

    typedef struct packed {
        blend_class_t cls;
        dest_pixel_t  pix;
        logic [15:0]  prod;
    } prod_stage_t;

    typedef struct packed {
        blend_class_t cls;
        dest_pixel_t  pix;
        logic [7:0]   ra;
        logic [15:0]  sum_b;
        logic [15:0]  sum_g;
        logic [15:0]  sum_r;
    } merge_stage_t;

    prod_stage_t   prod_reg;
    logic          prod_vld_reg;
    div_stage_t    div_reg [DIV_STEPS+1];
    logic          div_vld_reg [DIV_STEPS+1];
    merge_stage_t  merge_reg;
    logic          merge_vld_reg;
    result_pixel_t result_reg;
    logic          result_vld_reg;

    logic [7:0]    prod_q;
    logic [8:0]    ra_sum;
    logic [7:0]    ra_val;
    logic [7:0]    ratio;
    logic [7:0]    inv_ratio;
    logic [7:0]    blue_q;
    logic [7:0]    green_q;
    logic [7:0]    red_q;
    result_pixel_t result_next;
    div_stage_t    fin;

    // Valid bits of every stage; the pipeline advances each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg   <= 1'b0;
            merge_vld_reg  <= 1'b0;
            result_vld_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                div_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            prod_vld_reg   <= in_valid;
            div_vld_reg[0] <= prod_vld_reg;
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                div_vld_reg[i] <= div_vld_reg[i-1];
            end
            merge_vld_reg  <= div_vld_reg[DIV_STEPS];
            result_vld_reg <= merge_vld_reg;
        end
    end

    // Product of destination alpha and fill alpha.
    always_ff @(posedge clk)
    begin
        prod_reg.cls  <= in_item.cls;
        prod_reg.pix  <= in_item.pix;
        prod_reg.prod <= 16'(in_item.pix.dest_alpha_in * cfg.alpha);
    end

    // Result alpha b + s - b*s/255, which becomes the divisor of the ratio.
    assign prod_q = div255(prod_reg.prod);
    assign ra_sum = {1'b0, prod_reg.pix.dest_alpha_in} + {1'b0, cfg.alpha} - {1'b0, prod_q};
    assign ra_val = ra_sum[7:0];

    always_ff @(posedge clk)
    begin
        div_reg[0].cls     <= prod_reg.cls;
        div_reg[0].pix     <= prod_reg.pix;
        div_reg[0].ra      <= ra_val;
        div_reg[0].divisor <= (ra_val == 8'd0) ? 8'd1 : ra_val;
        div_reg[0].rem     <= {cfg.alpha, 8'd0} - {8'd0, cfg.alpha};
        div_reg[0].quot    <= 8'd0;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        localparam int unsigned BIT = DIV_STEPS - 1 - g;
        logic [15:0] shifted;
        logic        take;
        div_stage_t  step_next;

        assign shifted = 16'(div_reg[g].divisor) << BIT;
        assign take    = (div_reg[g].rem >= shifted);

        always_comb
        begin
            step_next           = div_reg[g];
            step_next.rem       = take ? (div_reg[g].rem - shifted) : div_reg[g].rem;
            step_next.quot[BIT] = take;
        end

        always_ff @(posedge clk)
        begin
            div_reg[g+1] <= step_next;
        end
    end

    // Channel merge d*(255-a) + c*a with the ratio or the fill alpha.
    assign fin       = div_reg[DIV_STEPS];
    assign ratio     = (fin.cls == CLS_BLEND) ? fin.quot : cfg.alpha;
    assign inv_ratio = BYTE_MAX - ratio;

    always_ff @(posedge clk)
    begin
        merge_reg.cls   <= fin.cls;
        merge_reg.pix   <= fin.pix;
        merge_reg.ra    <= fin.ra;
        merge_reg.sum_b <= 16'(fin.pix.dest_blue * inv_ratio) + 16'(cfg.blue * ratio);
        merge_reg.sum_g <= 16'(fin.pix.dest_green * inv_ratio) + 16'(cfg.green * ratio);
        merge_reg.sum_r <= 16'(fin.pix.dest_red * inv_ratio) + 16'(cfg.red * ratio);
    end

    // Final scaling and selection by item class.
    assign blue_q  = div255(merge_reg.sum_b);
    assign green_q = div255(merge_reg.sum_g);
    assign red_q   = div255(merge_reg.sum_r);

    always_comb
    begin
        result_next.out_blue  = merge_reg.pix.dest_blue;
        result_next.out_green = merge_reg.pix.dest_green;
        result_next.out_red   = merge_reg.pix.dest_red;
        result_next.out_alpha = merge_reg.pix.dest_alpha_in;
        case (merge_reg.cls)
            CLS_PASS:
            begin
            end
            CLS_FILL_KEEP, CLS_FILL_OPAQUE, CLS_FILL_SRC:
            begin
                result_next.out_blue  = cfg.blue;
                result_next.out_green = cfg.green;
                result_next.out_red   = cfg.red;
                if (merge_reg.cls == CLS_FILL_OPAQUE)
                begin
                    result_next.out_alpha = BYTE_MAX;
                end
                else if (merge_reg.cls == CLS_FILL_SRC)
                begin
                    result_next.out_alpha = cfg.alpha;
                end
            end
            CLS_MERGE_KEEP, CLS_MERGE_OPAQUE, CLS_BLEND:
            begin
                result_next.out_blue  = blue_q;
                result_next.out_green = green_q;
                result_next.out_red   = red_q;
                if (merge_reg.cls == CLS_MERGE_OPAQUE)
                begin
                    result_next.out_alpha = BYTE_MAX;
                end
                else if (merge_reg.cls == CLS_BLEND)
                begin
                    result_next.out_alpha = merge_reg.ra;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

endmodule

/* design/scob_checker.sv */
module scob_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic result_valid,
    input  logic cfg_valid,
    input  logic cfg_ready
);
    // Every accepted item comes out once it has passed the queue and every back-end stage.
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##13 result_valid)
        else $error("accepted item produced no result on schedule");

    // No result appears without a matching item accepted before it.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 13))
        else $error("result strobe without a matching item");

    // The pipeline never backs up, so busy stays low.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the back end never stalls");

    // Register writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind solid_color_over_blend scob_checker u_scob_checker (.*);
